[design/fbc_pkg.sv]
// shared types, constants and key selection function for the feistel block cipher
// no dependencies
package fbc_pkg;

  localparam int ROUND_COUNT_DEF = 16;
  localparam int KEY_REGS        = 8;
  localparam int KEY_REG_W       = 64;
  localparam int KEY_W           = KEY_REGS * KEY_REG_W;
  localparam int CFG_INDEX_W     = 4;
  localparam int HALF_W          = 32;
  localparam int BLOCK_W         = 2 * HALF_W;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic              dec;
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
  } stage_t;

  // four key bytes from byte idx on, wrapping mod 64, first byte most significant
  function automatic logic [HALF_W-1:0] key_word_at(input logic [KEY_W-1:0] key,
                                                    input logic [5:0] idx);
    logic [KEY_W+HALF_W-1:0] ext;
    ext = {key, key[KEY_W-1 -: HALF_W]};
    return ext[KEY_W+HALF_W-1 - {idx, 3'b000} -: HALF_W];
  endfunction

endpackage

[design/fbc_key_regs.sv]
// key register file written through the configuration port
// depends on fbc_pkg
module fbc_key_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fbc_pkg::KEY_REG_W-1:0]    cfg_data,
  output logic [fbc_pkg::KEY_W-1:0]        key
);

  logic [fbc_pkg::KEY_REG_W-1:0] key_reg [fbc_pkg::KEY_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbc_pkg::KEY_REGS; i++) key_reg[i] <= '0;
    end else if (cfg_write && (cfg_index < fbc_pkg::CFG_INDEX_W'(fbc_pkg::KEY_REGS))) begin
      key_reg[cfg_index[$clog2(fbc_pkg::KEY_REGS)-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < fbc_pkg::KEY_REGS; i++) begin
      key[fbc_pkg::KEY_W-1 - i*fbc_pkg::KEY_REG_W -: fbc_pkg::KEY_REG_W] = key_reg[i];
    end
  end

endmodule

[design/fbc_round.sv]
// one registered round stage with its own valid bit and stall handling
// depends on fbc_pkg
module fbc_round #(
  parameter int ENC_ROUND = 0,
  parameter int DEC_ROUND = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fbc_pkg::KEY_W-1:0] key,
  input  logic                      up_valid,
  input  fbc_pkg::stage_t           up_data,
  output logic                      up_ready,
  output logic                      valid,
  output fbc_pkg::stage_t           data,
  input  logic                      dn_ready
);

  localparam logic [5:0] ENC_OFF = 6'((8 * ENC_ROUND) % 64);
  localparam logic [5:0] DEC_OFF = 6'((8 * DEC_ROUND) % 64);

  logic [fbc_pkg::HALF_W-1:0] l_sel;
  logic [fbc_pkg::HALF_W-1:0] s_word;
  logic [5:0]                 idx;
  fbc_pkg::stage_t            data_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    if (up_data.dec == fbc_pkg::OP_DECRYPT) begin
      l_sel = {up_data.l[23:0], up_data.l[31:24]};
      idx   = l_sel[5:0] + DEC_OFF;
    end else begin
      l_sel = up_data.l;
      idx   = l_sel[5:0] + ENC_OFF;
    end
    s_word        = fbc_pkg::key_word_at(key, idx);
    data_next.dec = up_data.dec;
    data_next.r   = up_data.r ^ s_word;
    if (up_data.dec == fbc_pkg::OP_DECRYPT) begin
      data_next.l = l_sel;
    end else begin
      data_next.l = {up_data.l[7:0], up_data.l[31:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

endmodule

[design/feistel_block_cipher_64.sv]
// top level of the 64-bit feistel block cipher: key registers, whitening and round pipeline
// depends on fbc_pkg, fbc_key_regs and fbc_round
//
// One 64-bit word is accepted every cycle while the output is not stalled, and passes
// through these registers in order: one register for the input whitening, one register per
// round, and the output register with the final whitening. Each stage carries its own
// valid bit and loads whenever it is empty or the stage after it moves, so bubbles close
// up and a stalled output only holds the stages behind it that are full. The per-stage
// path is one 64-to-1 byte-rotation select of the key plus an xor. The key is taken live
// from the configuration registers and must only be written while the pipeline is empty.
module feistel_block_cipher_64 #(
  parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fbc_pkg::KEY_REG_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [fbc_pkg::BLOCK_W-1:0]       block_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fbc_pkg::BLOCK_W-1:0]       block_out
);

  logic [fbc_pkg::KEY_W-1:0]  key;
  logic [fbc_pkg::HALF_W-1:0] kw0, kw1, kw2, kw3;

  fbc_pkg::stage_t            st  [ROUND_COUNT+1];
  logic [ROUND_COUNT:0]       v;
  logic [ROUND_COUNT+1:0]     rdy;
  fbc_pkg::stage_t            st0_next;
  fbc_pkg::stage_t            st_in;
  logic                       v_in;

  fbc_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign kw0 = fbc_pkg::key_word_at(key, 6'd0);
  assign kw1 = fbc_pkg::key_word_at(key, 6'd4);
  assign kw2 = fbc_pkg::key_word_at(key, 6'd8);
  assign kw3 = fbc_pkg::key_word_at(key, 6'd12);

  // input whitening stage
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    st0_next.dec = opcode;
    if (opcode == fbc_pkg::OP_DECRYPT) begin
      st0_next.l = block_in[63:32] ^ kw2;
      st0_next.r = block_in[31:0] ^ kw3;
    end else begin
      st0_next.l = block_in[63:32] ^ kw0;
      st0_next.r = block_in[31:0] ^ kw1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (rdy[0]) begin
      v_in <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_in <= st0_next;
    end
  end

  assign v[0]  = v_in;
  assign st[0] = st_in;

  // round stages
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    fbc_round #(
      .ENC_ROUND (i),
      .DEC_ROUND (ROUND_COUNT - 1 - i)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .up_valid (v[i]),
      .up_data  (st[i]),
      .up_ready (rdy[i+1]),
      .valid    (v[i+1]),
      .data     (st[i+1]),
      .dn_ready (rdy[i+2])
    );
  end

  // output whitening stage
  assign rdy[ROUND_COUNT+1] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[ROUND_COUNT+1]) begin
      out_valid <= v[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ROUND_COUNT+1]) begin
      if (st[ROUND_COUNT].dec == fbc_pkg::OP_DECRYPT) begin
        block_out <= {st[ROUND_COUNT].l ^ kw0, st[ROUND_COUNT].r ^ kw1};
      end else begin
        block_out <= {st[ROUND_COUNT].l ^ kw2, st[ROUND_COUNT].r ^ kw3};
      end
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted word did not reach the whitening stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> in_ready)
    else $error("empty input stage refused a word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[0] && !rdy[1] |=> v[0] && $stable(st[0]))
    else $error("stalled input stage lost or changed its word");

  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    v[ROUND_COUNT] && out_valid && !out_ready |=> v[ROUND_COUNT])
    else $error("last round stage dropped a word under output stall");

endmodule
